// ===== rtl/umba_pkg.sv =====
package umba_pkg;

    // channel and divider widths
    localparam int CH_W      = 16;
    localparam int DIV_W     = CH_W + 1;
    localparam int QUO_W     = 16;
    localparam int REM_W     = 2 * CH_W + 2;
    localparam int DEN_W     = DIV_W + QUO_W - 1;
    localparam int NUM_LANES = 4;

    // lane order through the divider chain
    localparam int LANE_ALPHA = 0;
    localparam int LANE_RED   = 1;
    localparam int LANE_GREEN = 2;
    localparam int LANE_BLUE  = 3;

    // two set-up stages, one cell per quotient bit, one output stage
    localparam int PIPE_LATENCY = 2 + QUO_W + 1;

    // one division in flight: partial remainder, aligned divisor, quotient so far
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } umba_lane_t;

    // one pixel in flight
    typedef struct packed {
        logic                        deep;
        umba_lane_t [NUM_LANES-1:0]  lane;
    } umba_work_t;

endpackage

// ===== rtl/umba_prep.sv =====
module umba_prep
    import umba_pkg::*;
#(
    parameter int FULL_SCALE_DEEP = 32768,
    parameter int FULL_SCALE_BYTE = 255
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              deep,
    input  logic [CH_W-1:0]   alpha,
    input  logic [CH_W-1:0]   red,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   blue,
    output logic              out_valid,
    output umba_work_t        out_work
);

    logic             a_valid_reg;
    logic             a_deep_reg;
    logic [CH_W-1:0]  a_chan_reg [NUM_LANES];
    logic [CH_W-1:0]  a_max_reg;
    logic [CH_W-1:0]  a_max_next;
    logic [CH_W-1:0]  rg_max;

    logic             b_valid_reg;
    umba_work_t       b_work_reg;
    umba_work_t       b_work_next;

    logic [CH_W-1:0]    full;
    logic [2*CH_W-1:0]  prod [NUM_LANES];
    logic [DIV_W-1:0]   den_raw [NUM_LANES];
    logic [REM_W-1:0]   num [NUM_LANES];

    // largest colour channel
    always_comb
    begin
        rg_max     = (green > red) ? green : red;
        a_max_next = (blue > rg_max) ? blue : rg_max;
    end

    // stage a: channels and maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_deep_reg             <= deep;
        a_chan_reg[LANE_ALPHA] <= alpha;
        a_chan_reg[LANE_RED]   <= red;
        a_chan_reg[LANE_GREEN] <= green;
        a_chan_reg[LANE_BLUE]  <= blue;
        a_max_reg              <= a_max_next;
    end

    // stage b: numerators and divisors for the four divisions
    always_comb
    begin
        full = a_deep_reg ? CH_W'(FULL_SCALE_DEEP) : CH_W'(FULL_SCALE_BYTE);

        // derived alpha: max * alpha / full below full scale, else the max itself
        prod[LANE_ALPHA] = (2*CH_W)'(a_max_reg) * (2*CH_W)'(a_chan_reg[LANE_ALPHA]);
        if (a_chan_reg[LANE_ALPHA] < full)
        begin
            num[LANE_ALPHA]     = REM_W'(prod[LANE_ALPHA]);
            den_raw[LANE_ALPHA] = DIV_W'(full);
        end
        else
        begin
            num[LANE_ALPHA]     = REM_W'(a_max_reg);
            den_raw[LANE_ALPHA] = DIV_W'(1);
        end

        // colours: (2 * c * full + max) / (2 * max), rounds half up
        for (int i = LANE_RED; i <= LANE_BLUE; i++)
        begin
            prod[i]    = (2*CH_W)'(a_chan_reg[i]) * (2*CH_W)'(full);
            num[i]     = REM_W'({prod[i], 1'b0}) + REM_W'(a_max_reg);
            den_raw[i] = {a_max_reg, 1'b0};
        end

        b_work_next.deep = a_deep_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            b_work_next.lane[i].rem = num[i];
            b_work_next.lane[i].den = DEN_W'(den_raw[i]) << (QUO_W - 1);
            b_work_next.lane[i].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_work_reg <= b_work_next;
    end

    assign out_valid = b_valid_reg;
    assign out_work  = b_work_reg;

endmodule

// ===== rtl/umba_div_cell.sv =====
module umba_div_cell
    import umba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  umba_work_t  in_work,
    output logic        out_valid,
    output umba_work_t  out_work
);

    logic                  valid_reg;
    umba_work_t            work_reg;
    umba_work_t            work_next;
    logic [NUM_LANES-1:0]  fits;

    // one restoring step per lane: trial subtract, one quotient bit
    always_comb
    begin
        work_next.deep = in_work.deep;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            fits[i] = in_work.lane[i].rem >= REM_W'(in_work.lane[i].den);
            work_next.lane[i].rem = fits[i]
                ? in_work.lane[i].rem - REM_W'(in_work.lane[i].den)
                : in_work.lane[i].rem;
            work_next.lane[i].den = in_work.lane[i].den >> 1;
            work_next.lane[i].quo = {in_work.lane[i].quo[QUO_W-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== rtl/umba_post.sv =====
module umba_post
    import umba_pkg::*;
#(
    parameter int FULL_SCALE_DEEP = 32768,
    parameter int FULL_SCALE_BYTE = 255
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  umba_work_t       in_work,
    output logic             done,
    output logic [CH_W-1:0]  alpha_out,
    output logic [CH_W-1:0]  red_out,
    output logic [CH_W-1:0]  green_out,
    output logic [CH_W-1:0]  blue_out
);

    logic             done_reg;
    logic [CH_W-1:0]  chan_reg  [NUM_LANES];
    logic [CH_W-1:0]  chan_next [NUM_LANES];
    logic [CH_W-1:0]  full;
    logic             black;

    // clamp to full scale, force all zero when derived alpha is zero
    always_comb
    begin
        full  = in_work.deep ? CH_W'(FULL_SCALE_DEEP) : CH_W'(FULL_SCALE_BYTE);
        black = (in_work.lane[LANE_ALPHA].quo == '0);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (black)
            begin
                chan_next[i] = '0;
            end
            else if (in_work.lane[i].quo > full)
            begin
                chan_next[i] = full;
            end
            else
            begin
                chan_next[i] = in_work.lane[i].quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            chan_reg[i] <= chan_next[i];
        end
    end

    assign done      = done_reg;
    assign alpha_out = chan_reg[LANE_ALPHA];
    assign red_out   = chan_reg[LANE_RED];
    assign green_out = chan_reg[LANE_GREEN];
    assign blue_out  = chan_reg[LANE_BLUE];

endmodule

// ===== rtl/unmult_black_to_alpha_top.sv =====
// Unmult black to alpha: one ARGB pixel per clock in, one per clock out. A pixel is
// taken on start (busy is always low) and its result appears on the *_out ports for
// exactly one cycle with done, in input order. The receiver cannot stall, so every
// result must be captured in its done cycle. The pipeline is two set-up stages
// (channel maximum, then the multiplies), a chain of 16 divider cells that each
// resolve one quotient bit of all four divisions, and one output register.
// deep_mode (cfg_we/cfg_wdata) selects 8-bit or 16-bit full scale; change it only
// while no pixel is in the pipeline.
module unmult_black_to_alpha_top
    import umba_pkg::*;
#(
    parameter int FULL_SCALE_DEEP = 32768,
    parameter int FULL_SCALE_BYTE = 255
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic [CH_W-1:0]  alpha_in,
    input  logic [CH_W-1:0]  red_in,
    input  logic [CH_W-1:0]  green_in,
    input  logic [CH_W-1:0]  blue_in,
    output logic             done,
    output logic [CH_W-1:0]  alpha_out,
    output logic [CH_W-1:0]  red_out,
    output logic [CH_W-1:0]  green_out,
    output logic [CH_W-1:0]  blue_out
);

    logic          deep_mode_reg;
    logic          deep_mode_next;
    logic          accept;
    logic [QUO_W:0] chain_valid;
    umba_work_t    chain_work [QUO_W+1];

    // mode register
    assign deep_mode_next = cfg_we ? cfg_wdata : deep_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deep_mode_reg <= 1'b0;
        end
        else
        begin
            deep_mode_reg <= deep_mode_next;
        end
    end

    // fully pipelined, a transfer can be taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // maximum and multiplies
    umba_prep #(
        .FULL_SCALE_DEEP (FULL_SCALE_DEEP),
        .FULL_SCALE_BYTE (FULL_SCALE_BYTE)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .deep      (deep_mode_reg),
        .alpha     (alpha_in),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .out_valid (chain_valid[0]),
        .out_work  (chain_work[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar g = 0; g < QUO_W; g++)
    begin : g_cell
        umba_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_work   (chain_work[g]),
            .out_valid (chain_valid[g+1]),
            .out_work  (chain_work[g+1])
        );
    end

    // clamp and output register
    umba_post #(
        .FULL_SCALE_DEEP (FULL_SCALE_DEEP),
        .FULL_SCALE_BYTE (FULL_SCALE_BYTE)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[QUO_W]),
        .in_work   (chain_work[QUO_W]),
        .done      (done),
        .alpha_out (alpha_out),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

// ===== rtl/umba_checker.sv =====
module umba_checker
    import umba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [CH_W-1:0]  red_in,
    input  logic [CH_W-1:0]  green_in,
    input  logic [CH_W-1:0]  blue_in,
    input  logic             done,
    input  logic [CH_W-1:0]  alpha_out,
    input  logic [CH_W-1:0]  red_out,
    input  logic [CH_W-1:0]  green_out,
    input  logic [CH_W-1:0]  blue_out
);

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every transfer in gives a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("result missing after latency");

    // no result without a transfer in at the matching cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without input transfer");

    // transparent result carries black colours
    a_zero_alpha_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && alpha_out == '0) |->
            (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("colours not cleared with zero alpha");

    // black pixel in gives zero alpha out
    a_black_in: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && red_in == '0 && green_in == '0 && blue_in == '0)
            |-> ##PIPE_LATENCY (alpha_out == '0))
        else $error("black pixel gave non-zero alpha");

endmodule

bind unmult_black_to_alpha_top umba_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .done      (done),
    .alpha_out (alpha_out),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);

// ===== sim/tb_unmult_black_to_alpha_top.sv =====
module tb_unmult_black_to_alpha_top;
    import umba_pkg::*;

    localparam int FULL_DEEP    = 32768;
    localparam int FULL_BYTE    = 255;
    localparam int QUIET_LIMIT  = 500;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;

    // one ARGB pixel, in or out
    typedef struct {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // expected pixels in transfer order, with a local copy of the mode bit
    class unmult_scoreboard;
        bit     deep_mode = 1'b0;
        pixel_t expected_q[$];
        int     failures = 0;

        function void set_mode(bit m);
            deep_mode = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // colour scaled so that the largest channel reaches full, half up, clamped
        function longint unsigned rescaled(longint unsigned c, longint unsigned maxc,
                                           longint unsigned full);
            longint unsigned v;
            v = (2 * c * full + maxc) / (2 * maxc);
            return (v > full) ? full : v;
        endfunction

        function pixel_t unmult_pixel(pixel_t p);
            longint unsigned full;
            longint unsigned maxc;
            longint unsigned a;
            pixel_t          q;
            full = deep_mode ? FULL_DEEP : FULL_BYTE;
            maxc = p.red;
            if (p.green > maxc) maxc = p.green;
            if (p.blue > maxc) maxc = p.blue;
            // premultiply only when alpha is below full scale
            if (p.alpha < full)
                a = (maxc * p.alpha) / full;
            else
                a = maxc;
            if (a > full) a = full;
            // black, or alpha truncating to nothing, gives an empty pixel
            if (maxc == 0 || a == 0)
            begin
                q.alpha = '0;
                q.red   = '0;
                q.green = '0;
                q.blue  = '0;
            end
            else
            begin
                q.alpha = a[CH_W-1:0];
                q.red   = CH_W'(rescaled(p.red, maxc, full));
                q.green = CH_W'(rescaled(p.green, maxc, full));
                q.blue  = CH_W'(rescaled(p.blue, maxc, full));
            end
            return q;
        endfunction

        function void note_pixel(pixel_t p);
            expected_q.push_back(unmult_pixel(p));
        endfunction

        function void compare_field(string name, logic [CH_W-1:0] exp_v,
                                    logic [CH_W-1:0] got_v);
            if (got_v !== exp_v)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t exp_p;
            if (expected_q.size() == 0)
            begin
                failures++;
                $display("%0t: result with nothing expected, actual %0d %0d %0d %0d",
                         $time, got.alpha, got.red, got.green, got.blue);
                return;
            end
            exp_p = expected_q.pop_front();
            compare_field("alpha_out", exp_p.alpha, got.alpha);
            compare_field("red_out", exp_p.red, got.red);
            compare_field("green_out", exp_p.green, got.green);
            compare_field("blue_out", exp_p.blue, got.blue);
        endfunction
    endclass

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic            cfg_wdata = 1'b0;
    logic            start     = 1'b0;
    logic            busy;
    logic [CH_W-1:0] alpha_in  = '0;
    logic [CH_W-1:0] red_in    = '0;
    logic [CH_W-1:0] green_in  = '0;
    logic [CH_W-1:0] blue_in   = '0;
    logic            done;
    logic [CH_W-1:0] alpha_out;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;

    unmult_scoreboard sb;
    int               quiet_cycles = 0;
    bit               idle_on      = 1'b0;

    unmult_black_to_alpha_top #(
        .FULL_SCALE_DEEP (FULL_DEEP),
        .FULL_SCALE_BYTE (FULL_BYTE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .busy      (busy),
        .alpha_in  (alpha_in),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .done      (done),
        .alpha_out (alpha_out),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always #5 clk = ~clk;

    // monitor: mode writes, input transfers, results, and the watchdog
    always @(posedge clk)
    begin
        pixel_t p;
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_mode(cfg_wdata);
            if (start && !busy)
            begin
                p.alpha = alpha_in;
                p.red   = red_in;
                p.green = green_in;
                p.blue  = blue_in;
                sb.note_pixel(p);
            end
            if (done)
            begin
                p.alpha = alpha_out;
                p.red   = red_out;
                p.green = green_out;
                p.blue  = blue_out;
                sb.check_pixel(p);
            end
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one pixel and hold it until the transfer edge
    task send_pixel(logic [CH_W-1:0] a, logic [CH_W-1:0] r,
                    logic [CH_W-1:0] g, logic [CH_W-1:0] b);
        start    <= 1'b1;
        alpha_in <= a;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    task idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop sending until the pipeline has emptied
    task drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task write_mode(bit m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // channel value: mostly in range, some extremes, some raw 16-bit noise
    function automatic logic [CH_W-1:0] pick_channel(bit deep_m, bit is_alpha);
        int full;
        int sel;
        full = deep_m ? FULL_DEEP : FULL_BYTE;
        sel  = $urandom_range(0, 99);
        if (is_alpha && sel < 25)
            return CH_W'(full);
        if (sel < 60)
            return CH_W'($urandom_range(0, full));
        if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return CH_W'(1);
                2:       return CH_W'(full - 1);
                default: return CH_W'(full);
            endcase
        end
        if (sel < 88)
            return CH_W'($urandom_range(0, 3));
        return CH_W'($urandom_range(0, 65535));
    endfunction

    task random_phase(bit deep_m, int n, bit allow_idle);
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            // idling comes in stretches, with stretches of none between
            if (i % 40 == 0)
                idle_on = allow_idle && ($urandom_range(0, 9) < 7);
            a = pick_channel(deep_m, 1'b1);
            r = pick_channel(deep_m, 1'b0);
            g = pick_channel(deep_m, 1'b0);
            b = pick_channel(deep_m, 1'b0);
            // black pixels now and then
            if ($urandom_range(0, 19) == 0)
            begin
                r = '0;
                g = '0;
                b = '0;
            end
            send_pixel(a, r, g, b);
            if (idle_on && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 7));
            if (allow_idle && $urandom_range(0, 149) == 0)
                drain_pipeline();
        end
    endtask

    initial
    begin
        bit m;
        sb = new;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels, 8-bit mode
        write_mode(1'b0);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd255, 16'd255, 16'd255, 16'd255);
        send_pixel(16'd255, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd255, 16'd128, 16'd7);
        send_pixel(16'd255, 16'd255, 16'd0, 16'd0);
        send_pixel(16'd1, 16'd1, 16'd0, 16'd0);
        idle_cycles(3);
        send_pixel(16'd128, 16'd200, 16'd100, 16'd50);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd300, 16'd1000, 16'd0, 16'd255);
        send_pixel(16'd254, 16'd3, 16'd1, 16'd2);
        send_pixel(16'd255, 16'd2, 16'd1, 16'd0);
        send_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        drain_pipeline();

        // directed pixels, 16-bit mode
        write_mode(1'b1);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd32768, 16'd32768, 16'd32768, 16'd32768);
        send_pixel(16'd32768, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd32768, 16'd1, 16'd2);
        send_pixel(16'd32767, 16'd1, 16'd1, 16'd1);
        send_pixel(16'd16384, 16'd32768, 16'd16384, 16'd1);
        idle_cycles(5);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_pixel(16'd32768, 16'd2, 16'd1, 16'd0);
        send_pixel(16'd1000, 16'd65535, 16'd3, 16'd40000);
        send_pixel(16'd32769, 16'd12345, 16'd54321, 16'd0);
        send_pixel(16'd1, 16'd32768, 16'd32768, 16'd32768);
        drain_pipeline();

        // random phases, alternating then random modes; the last has no idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            m = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            write_mode(m);
            random_phase(m, PHASE_ITEMS, ph != NUM_PHASES - 1);
            drain_pipeline();
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/umba_pkg.sv
rtl/umba_prep.sv
rtl/umba_div_cell.sv
rtl/umba_post.sv
rtl/unmult_black_to_alpha_top.sv
rtl/umba_checker.sv
sim/tb_unmult_black_to_alpha_top.sv
